[hw/rtl/klex_pkg.sv]
// ----------------------------------------------------------------------------
// klex_pkg
// shared types, character codes and keyword table for the keyword lexer
// ----------------------------------------------------------------------------
package klex_pkg;

    localparam int MAX_ID_LEN_DEF = 32;
    localparam int CHAR_W         = 8;
    localparam int KW_NUM         = 5;
    localparam int KW_POS_W       = 3;
    localparam int KW_SLOTS       = 8;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;
    localparam logic [CHAR_W-1:0] CH_UNDER = 8'h5F;

    typedef enum logic [1:0] {
        KIND_CHAR    = 2'd0,
        KIND_KEYWORD = 2'd1,
        KIND_IDENT   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        KW_AGENT  = 3'd0,
        KW_HANDLE = 3'd1,
        KW_ORACLE = 3'd2,
        KW_STATE  = 3'd3,
        KW_REMOVE = 3'd4
    } kw_code_t;

    typedef enum logic [1:0] {
        MODE_START   = 2'd0,
        MODE_IDENT   = 2'd1,
        MODE_COMMENT = 2'd2
    } lex_mode_t;

    // keyword spellings, padded to a power-of-two slot count
    localparam logic [CHAR_W-1:0] KW_CHARS [KW_NUM][KW_SLOTS] = '{
        '{"a", "g", "e", "n", "t", 8'h00, 8'h00, 8'h00},
        '{"h", "a", "n", "d", "l", "e",   8'h00, 8'h00},
        '{"o", "r", "a", "c", "l", "e",   8'h00, 8'h00},
        '{"s", "t", "a", "t", "e", 8'h00, 8'h00, 8'h00},
        '{"r", "e", "m", "o", "v", "e",   8'h00, 8'h00}
    };

    localparam logic [KW_POS_W-1:0] KW_LEN [KW_NUM] = '{
        3'd5, 3'd6, 3'd6, 3'd5, 3'd6
    };

    // update request for the keyword tracker
    typedef struct packed {
        logic              start;
        logic              save;
        logic [CHAR_W-1:0] ch;
    } kw_cmd_t;

    // keyword tracker status
    typedef struct packed {
        logic     hit;
        kw_code_t code;
    } kw_hit_t;

    function automatic logic is_letter(input logic [CHAR_W-1:0] c);
        is_letter = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_ident_char(input logic [CHAR_W-1:0] c);
        is_ident_char = is_letter(c) || ((c >= "0") && (c <= "9")) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

[hw/rtl/klex_in_if.sv]
// ----------------------------------------------------------------------------
// klex_in_if
// character channel: valid/ready handshake with request type and byte
// ----------------------------------------------------------------------------
interface klex_in_if;

    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] in_char;

    modport source (output valid, output req_type, output in_char, input ready);
    modport sink   (input valid, input req_type, input in_char, output ready);

endinterface

[hw/rtl/klex_out_if.sv]
// ----------------------------------------------------------------------------
// klex_out_if
// token channel: valid/ready handshake with one token per transaction
// ----------------------------------------------------------------------------
interface klex_out_if;

    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic [2:0] keyword_code;
    logic       id_truncated;
    logic       run_last;

    modport source (
        output valid, output out_kind, output out_char, output keyword_code,
        output id_truncated, output run_last, input ready
    );
    modport sink (
        input valid, input out_kind, input out_char, input keyword_code,
        input id_truncated, input run_last, output ready
    );

endinterface

[hw/rtl/keyword_identifier_lexer_top.sv]
// ----------------------------------------------------------------------------
// keyword_identifier_lexer_top
// character lexer: skips blanks and comments, buffers identifiers in a ram
// and emits keyword tokens, identifier characters or single-char tokens
// ----------------------------------------------------------------------------
//
//   channel    dir   payload                                       handshake
//   char_ch    in    req_type, in_char                             valid/ready
//   token_ch   out   out_kind, out_char, keyword_code,             valid/ready
//                    id_truncated, run_last
//
// a character that yields at most one token is taken in ST_RUN; the next one
// can be taken as the token leaves the output register, unless token_ch stalls
// an identifier that ends without being a keyword sends its N buffered
// characters from ST_EMIT, then any trailing single-char token from ST_TAIL; the
// single read port of the identifier ram gives one character per cycle unless
// token_ch stalls; a keyword's trailing single-char token also comes from ST_TAIL
// reset is asynchronous active low and clears mode, length and flags; the
// identifier ram is not cleared, only written entries are ever read
// a stall on token_ch holds the output register and the ram read address
//
module keyword_identifier_lexer_top #(
    parameter int MAX_ID_LEN = klex_pkg::MAX_ID_LEN_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    klex_in_if.sink           char_ch,
    klex_out_if.source        token_ch
);

    import klex_pkg::*;

    localparam int AW = $clog2(MAX_ID_LEN);
    localparam int LW = $clog2(MAX_ID_LEN + 1);

    // sequencer states
    typedef enum logic [2:0] {
        ST_RUN  = 3'b001,
        ST_EMIT = 3'b010,
        ST_TAIL = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    lex_mode_t          mode_reg, mode_next;
    logic [LW-1:0]      len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      emit_last_reg, emit_last_next;
    logic               emit_trunc_reg, emit_trunc_next;
    logic               tail_valid_reg, tail_valid_next;
    logic [CHAR_W-1:0]  tail_char_reg, tail_char_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    kw_code_t           out_code_reg, out_code_next;
    logic               out_trunc_reg, out_trunc_next;
    logic               out_last_reg, out_last_next;

    // ram ports
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [CHAR_W-1:0]  rd_data;

    kw_cmd_t            kw_cmd;
    kw_hit_t            kw_hit;

    logic               out_free;
    logic               in_ready;
    logic               accept;
    logic [CHAR_W-1:0]  c;
    logic [LW-1:0]      len_m1;
    logic               end_tok;

    assign c        = char_ch.in_char;
    assign out_free = !out_valid_reg || token_ch.ready;
    assign in_ready = (state_reg == ST_RUN) && out_free;
    assign accept   = char_ch.valid && in_ready;
    assign len_m1   = len_reg - LW'(1);
    // the ending byte of an identifier yields a token unless blank or comment
    assign end_tok  = !is_blank(c) && (c != CH_HASH);

    klex_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (MAX_ID_LEN)
    ) u_ident_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (c),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    klex_kwmatch u_kwmatch (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (kw_cmd),
        .hit   (kw_hit)
    );

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        len_next        = len_reg;
        ovf_next        = ovf_reg;
        idx_next        = idx_reg;
        emit_last_next  = emit_last_reg;
        emit_trunc_next = emit_trunc_reg;
        tail_valid_next = tail_valid_reg;
        tail_char_next  = tail_char_reg;

        out_valid_next  = out_valid_reg && !token_ch.ready;
        out_kind_next   = out_kind_reg;
        out_char_next   = out_char_reg;
        out_code_next   = out_code_reg;
        out_trunc_next  = out_trunc_reg;
        out_last_next   = out_last_reg;

        wr_en     = 1'b0;
        wr_addr   = len_reg[AW-1:0];
        rd_addr   = idx_reg;
        kw_cmd    = '0;
        kw_cmd.ch = c;

        case (state_reg)
            ST_RUN:
            begin
                // prime the ram read of the first buffered character
                rd_addr = '0;
                if (accept)
                begin
                    if (char_ch.req_type)
                    begin
                        // restart drops any identifier in progress
                        len_next  = '0;
                        ovf_next  = 1'b0;
                        mode_next = MODE_START;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_COMMENT:
                            begin
                                if ((c == CH_LF) || (c == CH_CR))
                                begin
                                    mode_next = MODE_START;
                                end
                            end
                            MODE_IDENT:
                            begin
                                if (is_ident_char(c))
                                begin
                                    kw_cmd.save = 1'b1;
                                    if (len_reg < LW'(MAX_ID_LEN))
                                    begin
                                        wr_en    = 1'b1;
                                        len_next = len_reg + LW'(1);
                                    end
                                    else
                                    begin
                                        ovf_next = 1'b1;
                                    end
                                end
                                else
                                begin
                                    // identifier ends; ending byte handled as start mode
                                    len_next       = '0;
                                    ovf_next       = 1'b0;
                                    mode_next      = (c == CH_HASH) ? MODE_COMMENT : MODE_START;
                                    tail_char_next = c;
                                    if (kw_hit.hit && !ovf_reg)
                                    begin
                                        out_valid_next = 1'b1;
                                        out_kind_next  = KIND_KEYWORD;
                                        out_char_next  = '0;
                                        out_code_next  = kw_hit.code;
                                        out_trunc_next = 1'b0;
                                        out_last_next  = !end_tok;
                                        if (end_tok)
                                        begin
                                            state_next = ST_TAIL;
                                        end
                                    end
                                    else
                                    begin
                                        emit_last_next  = len_m1[AW-1:0];
                                        emit_trunc_next = ovf_reg;
                                        tail_valid_next = end_tok;
                                        idx_next        = '0;
                                        state_next      = ST_EMIT;
                                    end
                                end
                            end
                            default:
                            begin
                                if (is_letter(c) || (c == CH_UNDER))
                                begin
                                    kw_cmd.start = 1'b1;
                                    wr_en        = 1'b1;
                                    wr_addr      = '0;
                                    len_next     = LW'(1);
                                    ovf_next     = 1'b0;
                                    mode_next    = MODE_IDENT;
                                end
                                else if (is_blank(c))
                                begin
                                    mode_next = MODE_START;
                                end
                                else if (c == CH_HASH)
                                begin
                                    mode_next = MODE_COMMENT;
                                end
                                else
                                begin
                                    out_valid_next = 1'b1;
                                    out_kind_next  = KIND_CHAR;
                                    out_char_next  = c;
                                    out_code_next  = KW_AGENT;
                                    out_trunc_next = 1'b0;
                                    out_last_next  = 1'b1;
                                    mode_next      = MODE_START;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_EMIT:
            begin
                // rd_data holds entry idx_reg; advance the address only on load
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_IDENT;
                    out_char_next  = rd_data;
                    out_code_next  = KW_AGENT;
                    out_trunc_next = emit_trunc_reg;
                    out_last_next  = (idx_reg == emit_last_reg) && !tail_valid_reg;
                    if (idx_reg == emit_last_reg)
                    begin
                        state_next = tail_valid_reg ? ST_TAIL : ST_RUN;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        rd_addr  = idx_reg + AW'(1);
                    end
                end
            end
            ST_TAIL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_CHAR;
                    out_char_next  = tail_char_reg;
                    out_code_next  = KW_AGENT;
                    out_trunc_next = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_RUN;
            mode_reg       <= MODE_START;
            len_reg        <= '0;
            ovf_reg        <= 1'b0;
            tail_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            len_reg        <= len_next;
            ovf_reg        <= ovf_next;
            tail_valid_reg <= tail_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        emit_last_reg  <= emit_last_next;
        emit_trunc_reg <= emit_trunc_next;
        tail_char_reg  <= tail_char_next;
        out_kind_reg   <= out_kind_next;
        out_char_reg   <= out_char_next;
        out_code_reg   <= out_code_next;
        out_trunc_reg  <= out_trunc_next;
        out_last_reg   <= out_last_next;
    end

    assign char_ch.ready         = in_ready;
    assign token_ch.valid        = out_valid_reg;
    assign token_ch.out_kind     = out_kind_reg;
    assign token_ch.out_char     = out_char_reg;
    assign token_ch.keyword_code = out_code_reg;
    assign token_ch.id_truncated = out_trunc_reg;
    assign token_ch.run_last     = out_last_reg;

    // the buffer is never written while it is being read out
    a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |-> !wr_en)
        else $error("identifier ram written during emission");

    // read index stays within the buffered identifier
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (idx_reg <= emit_last_reg))
        else $error("emission index beyond identifier end");

    // identifier mode always has at least one buffered character
    a_ident_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_IDENT) |-> (len_reg != '0))
        else $error("identifier mode with empty buffer");

    // the sequencer state register stays one-hot
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

[hw/rtl/klex_ram.sv]
// ----------------------------------------------------------------------------
// klex_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module klex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/klex_kwmatch.sv]
// ----------------------------------------------------------------------------
// klex_kwmatch
// tracks, character by character, which keywords the buffered identifier
// still spells
// ----------------------------------------------------------------------------
module klex_kwmatch (
    input  logic              clk,
    input  logic              rst_n,
    input  klex_pkg::kw_cmd_t cmd,
    output klex_pkg::kw_hit_t hit
);

    import klex_pkg::*;

    logic [KW_NUM-1:0]   match_reg;
    logic [KW_NUM-1:0]   match_next;
    logic [KW_POS_W-1:0] cnt_reg;
    logic [KW_POS_W-1:0] cnt_next;

    always_comb
    begin
        match_next = match_reg;
        cnt_next   = cnt_reg;
        if (cmd.start)
        begin
            for (int i = 0; i < KW_NUM; i++)
            begin
                match_next[i] = (cmd.ch == KW_CHARS[i][0]);
            end
            cnt_next = KW_POS_W'(1);
        end
        else if (cmd.save)
        begin
            for (int i = 0; i < KW_NUM; i++)
            begin
                match_next[i] = match_reg[i] && (cnt_reg < KW_LEN[i])
                                && (cmd.ch == KW_CHARS[i][cnt_reg]);
            end
            // saturate once past the longest keyword
            if (cnt_reg != {KW_POS_W{1'b1}})
            begin
                cnt_next = cnt_reg + KW_POS_W'(1);
            end
        end
    end

    always_comb
    begin
        hit.hit  = 1'b0;
        hit.code = KW_AGENT;
        for (int i = KW_NUM - 1; i >= 0; i--)
        begin
            if (match_reg[i] && (cnt_reg == KW_LEN[i]))
            begin
                hit.hit  = 1'b1;
                hit.code = kw_code_t'(3'(i));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            match_reg <= match_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

[verif/lexer_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lexer_tb_pkg
// token predictor and scoreboard for the keyword lexer testbench
// ----------------------------------------------------------------------------
package lexer_tb_pkg;

    import klex_pkg::*;

    localparam int ID_MAX = MAX_ID_LEN_DEF;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] ch;
        kw_code_t   code;
        logic       trunc;
        logic       last;
    } token_t;

    class token_checker;

        lex_mode_t  mode;
        logic [7:0] id_chars [ID_MAX];
        int         id_len;
        bit         id_over;
        token_t     pending_tokens [$];
        int         errors;
        string      kw_names [KW_NUM];

        function new();
            kw_names = '{"agent", "handle", "oracle", "state", "remove"};
            mode     = MODE_START;
            id_len   = 0;
            id_over  = 1'b0;
            errors   = 0;
        endfunction

        static function bit letter(logic [7:0] c);
            return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
        endfunction

        static function bit word_char(logic [7:0] c);
            return letter(c) || (c >= 8'h30 && c <= 8'h39) || (c == CH_UNDER);
        endfunction

        static function bit blank(logic [7:0] c);
            return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
        endfunction

        function void push(kind_t k, logic [7:0] c, kw_code_t code, bit tr);
            token_t t;
            t.kind  = k;
            t.ch    = c;
            t.code  = code;
            t.trunc = tr;
            t.last  = 1'b0;
            pending_tokens.push_back(t);
        endfunction

        function void save(logic [7:0] c);
            if (id_len < ID_MAX) begin
                id_chars[id_len] = c;
                id_len++;
            end else begin
                id_over = 1'b1;
            end
        endfunction

        // keyword index of the buffered identifier, -1 if none
        function int keyword_of();
            bit hit;
            if (id_over)
                return -1;
            for (int i = 0; i < KW_NUM; i++) begin
                if (kw_names[i].len() == id_len) begin
                    hit = 1'b1;
                    for (int j = 0; j < id_len; j++)
                        if (id_chars[j] != kw_names[i][j])
                            hit = 1'b0;
                    if (hit)
                        return i;
                end
            end
            return -1;
        endfunction

        function void start_char(logic [7:0] c);
            if (letter(c) || c == CH_UNDER) begin
                id_len  = 0;
                id_over = 1'b0;
                save(c);
                mode = MODE_IDENT;
            end else if (blank(c)) begin
                mode = MODE_START;
            end else if (c == CH_HASH) begin
                mode = MODE_COMMENT;
            end else begin
                push(KIND_CHAR, c, KW_AGENT, 1'b0);
                mode = MODE_START;
            end
        endfunction

        // note one accepted character transaction and queue its tokens
        function void accept_char(bit req, logic [7:0] c);
            int n_prev;
            int code;
            n_prev = pending_tokens.size();
            if (req) begin
                id_len  = 0;
                id_over = 1'b0;
                mode    = MODE_START;
                return;
            end
            case (mode)
                MODE_IDENT: begin
                    if (word_char(c)) begin
                        save(c);
                    end else begin
                        code = keyword_of();
                        if (code >= 0)
                            push(KIND_KEYWORD, 8'h00, kw_code_t'(code), 1'b0);
                        else
                            for (int i = 0; i < id_len; i++)
                                push(KIND_IDENT, id_chars[i], KW_AGENT, id_over);
                        id_len  = 0;
                        id_over = 1'b0;
                        mode    = MODE_START;
                        start_char(c);
                    end
                end
                MODE_COMMENT: begin
                    if (c == CH_LF || c == CH_CR)
                        mode = MODE_START;
                end
                default: start_char(c);
            endcase
            if (pending_tokens.size() > n_prev)
                pending_tokens[pending_tokens.size() - 1].last = 1'b1;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("[tokens] mismatch: %s", msg);
        endtask

        // compare one accepted token against the oldest expected one
        task check_token(token_t got);
            token_t want;
            if (pending_tokens.size() == 0) begin
                report($sformatf("unexpected token kind=%0d char=%02h", got.kind, got.ch));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.ch !== want.ch)
                report($sformatf("char %02h, expected %02h", got.ch, want.ch));
            if (got.code !== want.code)
                report($sformatf("keyword code %0d, expected %0d", got.code, want.code));
            if (got.trunc !== want.trunc)
                report($sformatf("truncated %b, expected %b", got.trunc, want.trunc));
            if (got.last !== want.last)
                report($sformatf("run_last %b, expected %b", got.last, want.last));
        endtask

        function int outstanding();
            return pending_tokens.size();
        endfunction

    endclass

endpackage

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives character transactions into the keyword lexer and checks every
// token against a predictor, under random source idling and sink stalls
// ----------------------------------------------------------------------------
module tb_top;

    import klex_pkg::*;
    import lexer_tb_pkg::*;

    localparam int HOLD_CYCLES   = 300;   // long sink hold-off to fill the block
    localparam int RANDOM_ITEMS  = 184;
    localparam int PHASE_COUNT   = 4;
    localparam int SETTLE_CYCLES = 8;     // settle time past the last token

    logic clk = 1'b0;
    logic rst_n;

    klex_in_if  char_ch ();
    klex_out_if token_ch ();

    keyword_identifier_lexer_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .char_ch  (char_ch),
        .token_ch (token_ch)
    );

    token_checker tokens = new();

    int     src_idle_pct   = 0;
    int     sink_stall_pct = 0;
    bit     hold_go        = 1'b0;
    int     items_sent     = 0;
    token_t seen;

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // hard limit on the whole run
    initial
    begin
        #4_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // token sink: random stalls, plus one long hold-off on request,
    // counted here so the source keeps offering characters meanwhile
    // ------------------------------------------------------------------
    initial
    begin
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                hold_go        = 1'b0;
                token_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            token_ch.ready = ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // token monitor: sample at the rising edge, check against the predictor
    always @(posedge clk)
    begin
        if (rst_n && token_ch.valid === 1'b1 && token_ch.ready === 1'b1)
        begin
            seen.kind  = kind_t'(token_ch.out_kind);
            seen.ch    = token_ch.out_char;
            seen.code  = kw_code_t'(token_ch.keyword_code);
            seen.trunc = token_ch.id_truncated;
            seen.last  = token_ch.run_last;
            tokens.check_token(seen);
        end
    end

    // ------------------------------------------------------------------
    // character source
    // ------------------------------------------------------------------

    // one character transaction, with random idle cycles in front
    task automatic send_char(bit req, logic [7:0] c);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            char_ch.valid = 1'b0;
            @(negedge clk);
        end
        char_ch.valid    = 1'b1;
        char_ch.req_type = req;
        char_ch.in_char  = c;
        do
            @(posedge clk);
        while (char_ch.ready !== 1'b1);
        tokens.accept_char(req, c);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_char(1'b0, s[i]);
    endtask

    // random identifier character; a lead character is a letter or underscore
    function automatic logic [7:0] pick_word_char(bit lead);
        int r;
        r = lead ? $urandom_range(52) : $urandom_range(62);
        if (r < 26)
            return 8'(8'h61 + r);
        if (r < 52)
            return 8'(8'h41 + (r - 26));
        if (lead || r == 62)
            return CH_UNDER;
        return 8'(8'h30 + (r - 52));
    endfunction

    task automatic send_ident(int len);
        send_char(1'b0, pick_word_char(1'b1));
        for (int i = 1; i < len; i++)
            send_char(1'b0, pick_word_char(1'b0));
    endtask

    // comment body without line ends, then CR or LF to close it
    task automatic send_comment_tail();
        logic [7:0] c;
        repeat ($urandom_range(5))
        begin
            do
                c = 8'($urandom_range(255));
            while (c == CH_LF || c == CH_CR);
            send_char(1'b0, c);
        end
        send_char(1'b0, $urandom_range(1) ? CH_LF : CH_CR);
    endtask

    // character that ends an identifier: blank, comment or any other byte
    task automatic send_ender();
        int         r;
        logic [7:0] c;
        r = $urandom_range(99);
        if (r < 40)
        begin
            case ($urandom_range(3))
                0: c = CH_SPACE;
                1: c = CH_TAB;
                2: c = CH_LF;
                default: c = CH_CR;
            endcase
        end
        else if (r < 50)
            c = CH_HASH;
        else
        begin
            do
                c = 8'($urandom_range(255));
            while (token_checker::word_char(c));
        end
        send_char(1'b0, c);
        if (c == CH_HASH)
            send_comment_tail();
    endtask

    // one random phrase; mostly well-formed words with random content
    task automatic send_phrase();
        int    r;
        int    k;
        string w;
        r = $urandom_range(99);
        w = tokens.kw_names[$urandom_range(KW_NUM - 1)];
        if (r < 25)
        begin
            // exact keyword
            send_text(w);
            send_ender();
        end
        else if (r < 35)
        begin
            // near miss: clipped, extended or one letter in upper case
            case ($urandom_range(2))
                0: send_text(w.substr(0, w.len() - 2));
                1:
                begin
                    send_text(w);
                    send_char(1'b0, pick_word_char(1'b0));
                end
                default:
                begin
                    k    = $urandom_range(w.len() - 1);
                    w[k] = w[k] - 8'd32;
                    send_text(w);
                end
            endcase
            send_ender();
        end
        else if (r < 60)
        begin
            send_ident($urandom_range(1, 8));
            send_ender();
        end
        else if (r < 66)
        begin
            // around and past the buffer size, truncation included
            send_ident($urandom_range(ID_MAX - 4, ID_MAX + 8));
            send_ender();
        end
        else if (r < 78)
            send_char(1'b0, 8'($urandom_range(255)));
        else if (r < 86)
        begin
            send_char(1'b0, CH_HASH);
            send_comment_tail();
        end
        else if (r < 94)
        begin
            // restart, often with an identifier half done
            if ($urandom_range(1))
                send_ident($urandom_range(1, 6));
            send_char(1'b1, 8'($urandom_range(255)));
        end
        else
            send_ender();
    endtask

    // stop offering and wait until every expected token has come
    task automatic drain();
        @(negedge clk);
        char_ch.valid = 1'b0;
        while (tokens.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int target;

        char_ch.valid    = 1'b0;
        char_ch.req_type = 1'b0;
        char_ch.in_char  = 8'h00;
        rst_n            = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part, no idling
        send_char(1'b0, 8'h00);            // byte extremes pass through
        send_char(1'b0, 8'hFF);
        send_text("state");                // keyword state
        send_char(1'b0, 8'h00);            // keyword then trailing token
        send_text("ag");                   // restart drops a partial identifier
        send_char(1'b1, 8'h61);
        send_char(1'b0, "!");
        send_char(1'b0, CH_HASH);          // comment closed by CR
        send_char(1'b0, "x");
        send_char(1'b0, CH_CR);
        send_text("_9");                   // underscore lead, ended by a tab
        send_char(1'b0, CH_TAB);
        send_char(1'b0, "Z");              // identifier ended by a comment
        send_char(1'b0, CH_HASH);
        send_char(1'b0, CH_LF);
        drain();

        // random part in idling phases, draining between them
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 67; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 67; end
                default: begin src_idle_pct = 24; sink_stall_pct = 24; end
            endcase
            // long sink hold-off while the source keeps pushing
            if (p == 0)
                hold_go = 1'b1;
            target = items_sent + RANDOM_ITEMS / PHASE_COUNT;
            while (items_sent < target)
                send_phrase();
            // close any open identifier or comment so its tokens flush
            send_char(1'b0, CH_LF);
            drain();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (tokens.errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
